// ===== rtl/sle_pkg.sv =====
// Shared types, codes and constants for the sorted list engine.
package sle_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 2;
    localparam int OPCODE_W      = 2;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT    = 2'd0,
        OP_DELETE    = 2'd1,
        OP_READ_ASC  = 2'd2,
        OP_READ_DESC = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    typedef struct packed {
        logic ins;
        logic del;
        logic rd_start;
        logic rd_desc;
        logic rd_empty;
        logic rd_step;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic rd_last;
    } t_sts;

endpackage

// ===== rtl/sle_ctrl.sv =====
// Controller state machine that decodes transfers and sequences list reads.
module sle_ctrl
    import sle_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  t_sts                i_sts,
    output t_cmd                o_cmd,
    output logic                busy
);

    t_state  r_state;
    t_state  n_state;
    t_opcode w_op;
    logic    w_accept;
    logic    w_read;

    assign w_op     = t_opcode'(i_opcode);
    assign w_accept = start && (r_state == S_IDLE);
    assign w_read   = (w_op == OP_READ_ASC) || (w_op == OP_READ_DESC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && w_read && !i_sts.count_zero) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (i_sts.rd_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        busy  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_cmd.ins      = w_accept && (w_op == OP_INSERT);
                o_cmd.del      = w_accept && (w_op == OP_DELETE);
                o_cmd.rd_start = w_accept && w_read && !i_sts.count_zero;
                o_cmd.rd_empty = w_accept && w_read && i_sts.count_zero;
                o_cmd.rd_desc  = (w_op == OP_READ_DESC);
            end
            S_READ: begin
                o_cmd.rd_step = 1'b1;
                busy          = 1'b1;
            end
            default: begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/sle_datapath.sv =====
// Datapath with the compare-and-shift cell row, read pointer and result registers.
module sle_datapath
    import sle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    input  logic signed [VALUE_W-1:0]  i_value,
    output t_sts                       o_sts,
    output logic                       o_strobe,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_entry_value,
    output logic                       o_last,
    output logic [COUNT_OUT_W-1:0]     o_entry_count
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = $clog2(DEPTH);
    localparam int EW = CW + COUNT_OUT_W;

    logic signed [VALUE_W-1:0] r_entries [DEPTH];
    logic signed [VALUE_W-1:0] n_entries [DEPTH];
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [IW-1:0]             r_rd_k;
    logic                      r_rd_desc;

    logic                      r_strobe;
    t_status                   r_status;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_last;
    logic [COUNT_OUT_W-1:0]    r_ocount;

    logic [DEPTH-1:0]          w_gt;
    logic [DEPTH-1:0]          w_hit;
    logic                      w_full;
    logic                      w_found;
    logic                      w_write;
    logic [CW-1:0]             w_rev;
    logic [IW-1:0]             w_rd_idx;
    logic                      w_rd_last;
    logic [EW-1:0]             w_cnt_ext;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_found = w_hit[DEPTH-1];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_gt[i] = (CW'(i) >= r_count) || (r_entries[i] > i_value);
        end
        w_hit[0] = (r_count != '0) && (r_entries[0] == i_value);
        for (int i = 1; i < DEPTH; i++) begin
            w_hit[i] = w_hit[i-1] || ((CW'(i) < r_count) && (r_entries[i] == i_value));
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_entries[i] = r_entries[i];
            if (i_cmd.ins) begin
                if (w_gt[i]) begin
                    if (i == 0) begin
                        n_entries[i] = i_value;
                    end else if (!w_gt[i-1]) begin
                        n_entries[i] = i_value;
                    end else begin
                        n_entries[i] = r_entries[i-1];
                    end
                end
            end else if (w_hit[i] && (i < DEPTH - 1)) begin
                n_entries[i] = r_entries[i+1];
            end
        end
    end

    assign w_write = (i_cmd.ins && !w_full) || (i_cmd.del && w_found);

    always_comb begin
        n_count = r_count;
        if (i_cmd.ins && !w_full) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.del && w_found) begin
            n_count = r_count - CW'(1);
        end
    end

    assign w_rev     = r_count - CW'(1) - CW'(r_rd_k);
    assign w_rd_idx  = r_rd_desc ? w_rev[IW-1:0] : r_rd_k;
    assign w_rd_last = (CW'(r_rd_k) == (r_count - CW'(1)));
    assign w_cnt_ext = EW'(n_count);

    always_ff @(posedge i_clk) begin
        if (w_write) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_entries[i] <= n_entries[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
            r_rd_k   <= '0;
        end else begin
            r_count  <= n_count;
            r_strobe <= i_cmd.ins || i_cmd.del || i_cmd.rd_empty || i_cmd.rd_step;
            if (i_cmd.rd_start) begin
                r_rd_k <= '0;
            end else if (i_cmd.rd_step) begin
                r_rd_k <= r_rd_k + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_rd_desc <= i_cmd.rd_desc;
        end
        r_ocount <= w_cnt_ext[COUNT_OUT_W-1:0];
        r_value  <= i_cmd.rd_step ? r_entries[w_rd_idx] : '0;
        r_last   <= i_cmd.rd_step ? w_rd_last : 1'b1;
        if (i_cmd.ins) begin
            r_status <= w_full ? ST_FULL : ST_OK;
        end else if (i_cmd.del) begin
            r_status <= w_found ? ST_OK : ST_NOT_FOUND;
        end else if (i_cmd.rd_empty) begin
            r_status <= ST_NOT_FOUND;
        end else begin
            r_status <= ST_OK;
        end
    end

    assign o_sts.count_zero = (r_count == '0);
    assign o_sts.rd_last    = w_rd_last;

    assign o_strobe      = r_strobe;
    assign o_status      = r_status;
    assign o_entry_value = r_value;
    assign o_last        = r_last;
    assign o_entry_count = r_ocount;

endmodule

// ===== rtl/sorted_list_engine_top.sv =====
// Top level of the sorted list engine: controller plus cell-row datapath.
//
//  Channel   Direction  Handshake              Payload
//  command   in         start, busy            i_opcode, i_value
//  result    out        o_strobe (no stall)    o_status, o_entry_value, o_last, o_entry_count
//
// An insert or delete transfer's result appears in the cycle after the transfer is taken.
// A read of a non-empty list streams one result per entry, busy being high meanwhile.
// A read of an empty list and all other commands give a single result with o_last set.
// Reset is synchronous and active low; it empties the list and idles the controller.
// The receiver cannot stall, so each result is shown for exactly one cycle.
module sorted_list_engine_top
    import sle_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OPCODE_W-1:0]        i_opcode,
    input  logic signed [VALUE_W-1:0]  i_value,
    output logic                       o_strobe,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [VALUE_W-1:0]  o_entry_value,
    output logic                       o_last,
    output logic [COUNT_OUT_W-1:0]     o_entry_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    sle_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_opcode (i_opcode),
        .i_sts    (w_sts),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    sle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_value       (i_value),
        .o_sts         (w_sts),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_entry_value (o_entry_value),
        .o_last        (o_last),
        .o_entry_count (o_entry_count)
    );

endmodule

// ===== rtl/sle_checker.sv =====
// Port-level checker for the sorted list engine, bound to the top level.
module sle_checker
    import sle_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [OPCODE_W-1:0]        i_opcode,
    input logic                       o_strobe,
    input logic [STATUS_W-1:0]        o_status,
    input logic signed [VALUE_W-1:0]  o_entry_value,
    input logic                       o_last
);

    a_update_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_INSERT || i_opcode == OP_DELETE))
        |=> (o_strobe && o_last))
        else $error("Insert or delete transfer did not give a single result.");

    a_read_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_opcode == OP_READ_ASC || i_opcode == OP_READ_DESC))
        |=> (o_strobe || busy))
        else $error("Read transfer neither answered nor started streaming.");

    a_stream_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> busy)
        else $error("Block accepts commands while a read stream is unfinished.");

    a_stream_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("Read stream has a gap.");

    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_FULL) |-> (o_last && o_entry_value == '0))
        else $error("Full status on a result that is not a refused insert.");

endmodule

bind sorted_list_engine_top sle_checker u_sle_checker (.*);
